// ===== hw/rtl/gca_pkg.sv =====
package gca_pkg;

	localparam int MAX_GRID_SIDE = 1024;
	localparam int CORDIC_STEPS  = 16;

	localparam int ROW_W  = 11;
	localparam int COL_W  = 10;
	localparam int CNT_W  = 21;
	localparam int SUM_W  = 32;
	localparam int DIST_W = 22;
	localparam int QUO_W  = 31;
	localparam int MEAN_W = 12;
	localparam int CX_W   = 34;
	localparam int Z_W    = 20;
	localparam int ATAN_N = 24;
	localparam int IDX_W  = 5;

	localparam logic signed [Z_W-1:0] HALF_PI_Q16  = 20'sd102944;
	localparam logic signed [31:0]    CMD_NONE_LIN = -32'sd5243;
	localparam logic signed [31:0]    CMD_NONE_ANG = 32'sd32768;
	localparam logic signed [31:0]    CMD_OFF_ANG  = 32'sd52429;

	localparam logic [1:0] OUTCOME_OFF   = 2'd0;
	localparam logic [1:0] OUTCOME_NONE  = 2'd1;
	localparam logic [1:0] OUTCOME_STEER = 2'd2;

	typedef struct packed {
		logic [10:0]        grid_width;
		logic signed [10:0] rect_x_low;
		logic signed [10:0] rect_x_high;
		logic signed [10:0] rect_y_low;
		logic signed [10:0] rect_y_high;
	} region_cfg_t;

	typedef struct packed {
		logic             start;
		logic [QUO_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [16:0] atan_entry(input logic [IDX_W-1:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0: v = 17'd51472;
			5'd1: v = 17'd30386;
			5'd2: v = 17'd16055;
			5'd3: v = 17'd8150;
			5'd4: v = 17'd4091;
			5'd5: v = 17'd2047;
			5'd6: v = 17'd1024;
			5'd7: v = 17'd512;
			5'd8: v = 17'd256;
			5'd9: v = 17'd128;
			5'd10: v = 17'd64;
			5'd11: v = 17'd32;
			5'd12: v = 17'd16;
			5'd13: v = 17'd8;
			5'd14: v = 17'd4;
			5'd15: v = 17'd2;
			5'd16: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/gca_accum.sv =====
module gca_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic signed [7:0]           occupancy,
	input  gca_pkg::region_cfg_t        cfg,
	input  logic                        clear,
	output logic [gca_pkg::CNT_W-1:0]   occupied_count,
	output logic signed [gca_pkg::SUM_W-1:0] x_sum,
	output logic signed [gca_pkg::SUM_W-1:0] y_sum,
	output logic [gca_pkg::DIST_W-1:0]  nearest_sq_dist
);
	import gca_pkg::*;

	logic [ROW_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  xs_q, ys_q;
	logic [DIST_W-1:0]        dist_q;
	logic [10:0]              w;
	logic signed [11:0]       x12, y12;
	logic signed [23:0]       xx, yy;
	logic [DIST_W:0]          d;
	logic                     hit;
	logic                     row_ok;
	logic [10:0]              col_next;

	always_comb begin
		if (cfg.grid_width == 11'd0)
			w = 11'd1;
		else if (cfg.grid_width > 11'(MAX_GRID_SIDE))
			w = 11'(MAX_GRID_SIDE);
		else
			w = cfg.grid_width;
		row_ok = row_q < ROW_W'(MAX_GRID_SIDE);
		x12 = $signed({2'b00, w[10:1]}) - 12'sd1 - $signed({1'b0, row_q});
		y12 = $signed({2'b00, col_q});
		xx = x12 * x12;
		yy = y12 * y12;
		d = xx[DIST_W:0] + yy[DIST_W:0];
		hit = (occupancy == 8'sd100) && row_ok &&
			(x12 >= $signed({cfg.rect_x_low[10], cfg.rect_x_low})) &&
			(x12 <= $signed({cfg.rect_x_high[10], cfg.rect_x_high})) &&
			(y12 >= $signed({cfg.rect_y_low[10], cfg.rect_y_low})) &&
			(y12 <= $signed({cfg.rect_y_high[10], cfg.rect_y_high}));
		col_next = {1'b0, col_q} + 11'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
			xs_q <= '0;
			ys_q <= '0;
			dist_q <= '1;
		end else if (clear) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
			xs_q <= '0;
			ys_q <= '0;
			dist_q <= '1;
		end else if (accept) begin
			if (hit) begin
				cnt_q <= cnt_q + CNT_W'(1);
				xs_q <= xs_q + SUM_W'(x12);
				ys_q <= ys_q + SUM_W'(y12);
				if (d[DIST_W-1:0] < dist_q)
					dist_q <= d[DIST_W-1:0];
			end
			if (row_ok) begin
				if (col_next >= w) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_next[COL_W-1:0];
				end
			end
		end
	end

	assign occupied_count = cnt_q;
	assign x_sum = xs_q;
	assign y_sum = ys_q;
	assign nearest_sq_dist = dist_q;

endmodule

// ===== hw/rtl/gca_div.sv =====
module gca_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gca_pkg::div_req_t req,
	output gca_pkg::div_rsp_t rsp
);
	import gca_pkg::*;

	logic [CNT_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] dvs_q;
	logic [4:0]       cnt_q;
	logic             busy_q, done_q;
	logic [CNT_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[QUO_W-1]};
		fits = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 5'(QUO_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUO_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/gca_cordic.sv =====
module gca_cordic #(
	parameter int CORDIC_STEPS = gca_pkg::CORDIC_STEPS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [gca_pkg::MEAN_W-1:0] yv,
	input  logic signed [gca_pkg::MEAN_W-1:0] xv,
	output logic                            done,
	output logic signed [gca_pkg::Z_W-1:0]  angle
);
	import gca_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

	logic signed [CX_W-1:0] x_q, y_q, xs, ys, dx, dy;
	logic signed [Z_W-1:0]  z_q;
	logic [IDX_W-1:0]       i_q;
	logic                   busy_q, done_q;
	logic signed [Z_W-1:0]  at;

	always_comb begin
		xs = CX_W'(xv) <<< 16;
		ys = CX_W'(yv) <<< 16;
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = $signed({3'b000, atan_entry(i_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= start ? (xv == '0 && yv == '0) :
				(busy_q && (i_q == IDX_W'(NSTEP - 1)));
			if (start) begin
				i_q <= '0;
				if (!(xv == '0 && yv == '0))
					busy_q <= 1'b1;
			end else if (busy_q) begin
				i_q <= i_q + IDX_W'(1);
				if (i_q == IDX_W'(NSTEP - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (xv == '0 && yv == '0) begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end else if (xs < 0) begin
				if (ys >= 0) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= HALF_PI_Q16;
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -HALF_PI_Q16;
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;
	assign angle = z_q;

endmodule

// ===== hw/rtl/grid_centroid_avoidance_cmd.sv =====
// channel   direction  handshake          payload
// cells     in         in_valid/in_stall  occupancy, last_cell
// command   out        out_valid/out_stall linear_cmd, angular_cmd, outcome
// config    in         apb write/read     paddr, pwdata, prdata
// an ordinary cell never raises in_stall; a steered last cell holds in_stall through
// the check, two bit-serial divisions, the CORDIC rotations, two multiply steps and
// the output load; a disabled or empty frame goes from the check to the output load
// a busy output register adds its stall time
// the command waits in an output register while out_stall holds; cells still flow
// reset clears counters, sums and the sequencer; registers return to their defaults
module grid_centroid_avoidance_cmd #(
	parameter int CORDIC_STEPS = gca_pkg::CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [7:0] occupancy,
	input  logic        last_cell,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] linear_cmd,
	output logic signed [31:0] angular_cmd,
	output logic [1:0]  outcome,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gca_pkg::*;

	localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
	localparam logic [2:0] REG_RECT_X_LOW   = 3'd1;
	localparam logic [2:0] REG_RECT_X_HIGH  = 3'd2;
	localparam logic [2:0] REG_RECT_Y_LOW   = 3'd3;
	localparam logic [2:0] REG_RECT_Y_HIGH  = 3'd4;
	localparam logic [2:0] REG_GAIN_LINEAR  = 3'd5;
	localparam logic [2:0] REG_GAIN_ANGULAR = 3'd6;
	localparam logic [2:0] REG_AVOID_ENABLE = 3'd7;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_CHK  = 8'b00000010,
		S_DIVX = 8'b00000100,
		S_DIVY = 8'b00001000,
		S_CORD = 8'b00010000,
		S_MULL = 8'b00100000,
		S_MULA = 8'b01000000,
		S_FIN  = 8'b10000000
	} seq_state_t;

	seq_state_t state_q;
	region_cfg_t cfg_q;
	logic [23:0]        gain_lin_q;
	logic signed [23:0] gain_ang_q;
	logic               enable_q;

	logic               in_acc, wr_en, clear;
	logic [CNT_W-1:0]   occ_cnt;
	logic signed [SUM_W-1:0] xsum, ysum;
	logic [DIST_W-1:0]  near_dist;
	div_req_t           dreq;
	div_rsp_t           drsp;
	logic               cord_start, cord_done;
	logic signed [Z_W-1:0] z;
	logic signed [MEAN_W-1:0] mx_q, my_new;
	logic signed [SUM_W-1:0] xneg, yneg;
	logic signed [24:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [47:0] prod, ang_r;
	logic signed [31:0] lin_q, ang_q, lin_sat, ang_sat;
	logic [1:0]         outc_q;
	logic               ov_q;
	logic signed [31:0] lin_o_q, ang_o_q;
	logic [1:0]         outc_o_q;
	logic               out_free;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign in_stall = state_q != S_IDLE;
	assign in_acc = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;
	assign clear = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width <= 11'd64;
			cfg_q.rect_x_low <= '0;
			cfg_q.rect_x_high <= '0;
			cfg_q.rect_y_low <= '0;
			cfg_q.rect_y_high <= '0;
			gain_lin_q <= '0;
			gain_ang_q <= '0;
			enable_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_GRID_WIDTH:   cfg_q.grid_width <= pwdata[10:0];
				REG_RECT_X_LOW:   cfg_q.rect_x_low <= pwdata[10:0];
				REG_RECT_X_HIGH:  cfg_q.rect_x_high <= pwdata[10:0];
				REG_RECT_Y_LOW:   cfg_q.rect_y_low <= pwdata[10:0];
				REG_RECT_Y_HIGH:  cfg_q.rect_y_high <= pwdata[10:0];
				REG_GAIN_LINEAR:  gain_lin_q <= pwdata[23:0];
				REG_GAIN_ANGULAR: gain_ang_q <= pwdata[23:0];
				REG_AVOID_ENABLE: enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GRID_WIDTH:   prdata = {21'd0, cfg_q.grid_width};
			REG_RECT_X_LOW:   prdata = 32'(cfg_q.rect_x_low);
			REG_RECT_X_HIGH:  prdata = 32'(cfg_q.rect_x_high);
			REG_RECT_Y_LOW:   prdata = 32'(cfg_q.rect_y_low);
			REG_RECT_Y_HIGH:  prdata = 32'(cfg_q.rect_y_high);
			REG_GAIN_LINEAR:  prdata = {8'd0, gain_lin_q};
			REG_GAIN_ANGULAR: prdata = 32'(gain_ang_q);
			REG_AVOID_ENABLE: prdata = {31'd0, enable_q};
			default:          prdata = '0;
		endcase
	end

	gca_accum u_accum (
		.clk(clk), .arst_n(arst_n), .accept(in_acc), .occupancy(occupancy),
		.cfg(cfg_q), .clear(clear), .occupied_count(occ_cnt), .x_sum(xsum),
		.y_sum(ysum), .nearest_sq_dist(near_dist)
	);

	gca_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	gca_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .yv(mx_q), .xv(my_new),
		.done(cord_done), .angle(z)
	);

	always_comb begin
		xneg = -xsum;
		yneg = -ysum;
		dreq.divisor = occ_cnt;
		dreq.dividend = (state_q == S_CHK) ?
			(xsum[SUM_W-1] ? xneg[QUO_W-1:0] : xsum[QUO_W-1:0]) :
			(ysum[SUM_W-1] ? yneg[QUO_W-1:0] : ysum[QUO_W-1:0]);
		dreq.start = ((state_q == S_CHK) && enable_q && occ_cnt != '0) ||
			((state_q == S_DIVX) && drsp.done);
		my_new = ysum[SUM_W-1] ? -$signed(drsp.quotient[MEAN_W-1:0]) :
			$signed(drsp.quotient[MEAN_W-1:0]);
		cord_start = (state_q == S_DIVY) && drsp.done;

		if (state_q == S_MULL) begin
			mul_a = $signed({1'b0, gain_lin_q});
			mul_b = $signed({1'b0, near_dist});
		end else begin
			mul_a = 25'(gain_ang_q);
			mul_b = 23'(z);
		end
		prod = 48'(mul_a) * 48'(mul_b);
		lin_sat = (prod > 48'sd2147483647) ? 32'sh7fffffff : prod[31:0];
		ang_r = (prod + 48'sd32768) >>> 16;
		if (ang_r > 48'sd2147483647)
			ang_sat = 32'sh7fffffff;
		else if (ang_r < -48'sd2147483648)
			ang_sat = 32'sh80000000;
		else
			ang_sat = ang_r[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_acc && last_cell) state_q <= S_CHK;
				S_CHK: begin
					if (enable_q && occ_cnt != '0)
						state_q <= S_DIVX;
					else
						state_q <= S_FIN;
				end
				S_DIVX: if (drsp.done) state_q <= S_DIVY;
				S_DIVY: if (drsp.done) state_q <= S_CORD;
				S_CORD: if (cord_done) state_q <= S_MULL;
				S_MULL: state_q <= S_MULA;
				S_MULA: state_q <= S_FIN;
				S_FIN: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CHK: begin
				if (!enable_q) begin
					lin_q <= '0;
					ang_q <= CMD_OFF_ANG;
					outc_q <= OUTCOME_OFF;
				end else begin
					lin_q <= CMD_NONE_LIN;
					ang_q <= CMD_NONE_ANG;
					outc_q <= (occ_cnt == '0) ? OUTCOME_NONE : OUTCOME_STEER;
				end
			end
			S_DIVX: begin
				if (drsp.done)
					mx_q <= xsum[SUM_W-1] ? -$signed(drsp.quotient[MEAN_W-1:0]) :
						$signed(drsp.quotient[MEAN_W-1:0]);
			end
			S_MULL: lin_q <= lin_sat;
			S_MULA: ang_q <= ang_sat;
			S_FIN: begin
				if (out_free) begin
					lin_o_q <= lin_q;
					ang_o_q <= ang_q;
					outc_o_q <= outc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign linear_cmd = lin_o_q;
	assign angular_cmd = ang_o_q;
	assign outcome = outc_o_q;

endmodule

// ===== dv/grid_centroid_avoidance_cmd_tb.sv =====
`timescale 1ns / 1ps

module grid_centroid_avoidance_cmd_tb;
	import gca_pkg::*;

	localparam int REG_WIDTH = 0;
	localparam int REG_XLO   = 1;
	localparam int REG_XHI   = 2;
	localparam int REG_YLO   = 3;
	localparam int REG_YHI   = 4;
	localparam int REG_GLIN  = 5;
	localparam int REG_GANG  = 6;
	localparam int REG_EN    = 7;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [31:0] lin;
		logic signed [31:0] ang;
		logic [1:0]         oc;
	} cmd_t;

	typedef struct {
		logic signed [7:0] occ;
		logic              last;
		logic              has_cmd;
		cmd_t              cmd;
	} cell_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic signed [7:0] occupancy = 0;
	logic last_cell = 0;
	logic out_stall = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	wire in_stall, out_valid, pready;
	wire signed [31:0] linear_cmd, angular_cmd;
	wire [1:0] outcome;
	wire [31:0] prdata;

	grid_centroid_avoidance_cmd u_top (.*);

	always #2 clk = ~clk;

	// register shadow
	logic [10:0] s_width;
	logic signed [10:0] s_xlo, s_xhi, s_ylo, s_yhi;
	logic [23:0] s_glin;
	logic signed [23:0] s_gang;
	logic s_en;
	// frame accumulators
	longint f_row, f_col, f_cnt, f_sx, f_sy, f_near;

	cmd_t cmd_q[$];
	int errors = 0;
	int cycles = 0;
	bit stall_mode = 0;
	bit bursting = 1;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint centroid_angle(longint yv, longint xv);
		longint x, y, z, t, dx, dy;
		int atab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		x = xv * 65536; y = yv * 65536; z = 0;
		if (xv == 0 && yv == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 102944;
			end else begin
				t = x; x = -y; y = t; z = -102944;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshr(y, i); dy = fshr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += (i < 17) ? atab[i] : 0;
			end else begin
				x -= dx; y += dy; z -= (i < 17) ? atab[i] : 0;
			end
		end
		return z;
	endfunction

	function automatic void frame_clear();
		f_row = 0; f_col = 0; f_cnt = 0; f_sx = 0; f_sy = 0; f_near = 4194303;
	endfunction

	function automatic bit predict_cell(logic signed [7:0] occ, logic last, output cmd_t c);
		longint w, x, y, d, a;
		w = s_width;
		if (w == 0) w = 1;
		if (w > MAX_GRID_SIDE) w = MAX_GRID_SIDE;
		if (f_row < MAX_GRID_SIDE) begin
			x = w / 2 - 1 - f_row;
			y = f_col;
			if (occ == 100 && x >= s_xlo && x <= s_xhi && y >= s_ylo && y <= s_yhi) begin
				d = x * x + y * y;
				f_cnt++; f_sx += x; f_sy += y;
				if (d < f_near) f_near = d;
			end
			if (f_col + 1 >= w) begin
				f_col = 0; f_row++;
			end else f_col++;
		end
		if (!last) return 0;
		if (!s_en) begin
			c.lin = 0; c.ang = CMD_OFF_ANG; c.oc = OUTCOME_OFF;
		end else if (f_cnt == 0) begin
			c.lin = CMD_NONE_LIN; c.ang = CMD_NONE_ANG; c.oc = OUTCOME_NONE;
		end else begin
			a = centroid_angle(f_sx / f_cnt, f_sy / f_cnt);
			c.lin = sat32(longint'(s_glin) * f_near);
			c.ang = sat32(fshr(longint'(s_gang) * a + 32768, 16));
			c.oc = OUTCOME_STEER;
		end
		frame_clear();
		return 1;
	endfunction

	task automatic reg_write(int idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_WIDTH: s_width = val[10:0];
			REG_XLO:   s_xlo = val[10:0];
			REG_XHI:   s_xhi = val[10:0];
			REG_YLO:   s_ylo = val[10:0];
			REG_YHI:   s_yhi = val[10:0];
			REG_GLIN:  s_glin = val[23:0];
			REG_GANG:  s_gang = val[23:0];
			REG_EN:    s_en = val[0];
			default: ;
		endcase
	endtask

	task automatic send_cell(logic signed [7:0] occ, logic last);
		cmd_t c;
		if (!bursting) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			bursting = 1;
		end
		in_valid <= 1; occupancy <= occ; last_cell <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (predict_cell(occ, last, c)) cmd_q.push_back(c);
		if ($urandom_range(0, 9) == 0) bursting = 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (cmd_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_region(int w, int xl, int xh, int yl, int yh, int gl, int ga, bit en);
		reg_write(REG_WIDTH, w); reg_write(REG_XLO, xl); reg_write(REG_XHI, xh);
		reg_write(REG_YLO, yl); reg_write(REG_YHI, yh); reg_write(REG_GLIN, gl);
		reg_write(REG_GANG, ga); reg_write(REG_EN, en);
	endtask

	// receiver: stalls on its own pattern, checks each transaction
	always @(posedge clk) begin
		cmd_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cmd_q.size() == 0) begin
					errors++;
					$display("%0t unexpected transaction %0d %0d %0d", $time,
						linear_cmd, angular_cmd, outcome);
				end else begin
					e = cmd_q.pop_front();
					if (linear_cmd !== e.lin) begin
						errors++;
						$display("%0t linear_cmd exp %0d got %0d", $time, e.lin, linear_cmd);
					end
					if (angular_cmd !== e.ang) begin
						errors++;
						$display("%0t angular_cmd exp %0d got %0d", $time, e.ang, angular_cmd);
					end
					if (outcome !== e.oc) begin
						errors++;
						$display("%0t outcome exp %0d got %0d", $time, e.oc, outcome);
					end
				end
			end
			if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
			out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
		end
	end

	cell_row_t dir_tab[$];

	function automatic cell_row_t row(logic signed [7:0] o, logic l, bit h, int lin, int ang,
		logic [1:0] oc);
		cell_row_t r;
		r.occ = o; r.last = l; r.has_cmd = h;
		r.cmd.lin = lin; r.cmd.ang = ang; r.cmd.oc = oc;
		return r;
	endfunction

	// walks the table; rows with a typed command are held to it
	task automatic run_table();
		cmd_t p;
		foreach (dir_tab[i]) begin
			send_cell(dir_tab[i].occ, dir_tab[i].last);
			if (dir_tab[i].has_cmd) begin
				if (cmd_q.size() == 0) begin
					errors++;
					$display("%0t row %0d exp a transaction got none", $time, i);
				end else begin
					p = cmd_q[$];
					if (p.lin !== dir_tab[i].cmd.lin || p.ang !== dir_tab[i].cmd.ang ||
						p.oc !== dir_tab[i].cmd.oc) begin
						errors++;
						$display("%0t row %0d exp %0d %0d %0d got %0d %0d %0d", $time, i,
							dir_tab[i].cmd.lin, dir_tab[i].cmd.ang, dir_tab[i].cmd.oc,
							p.lin, p.ang, p.oc);
					end
				end
			end
		end
	endtask

	initial begin
		int w, ncell;
		logic signed [7:0] o;
		s_width = 64; s_xlo = 0; s_xhi = 0; s_ylo = 0; s_yhi = 0;
		s_glin = 0; s_gang = 0; s_en = 0;
		frame_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset: disabled
		dir_tab.push_back(row(100, 1, 1, 0, CMD_OFF_ANG, OUTCOME_OFF));
		run_table();
		drain();
		dir_tab.delete();

		// enabled, no cell in the region: no obstacle
		set_region(4, -1024, -1024, 1023, 1023, 24'hFFFFFF, 24'h7FFFFF, 1);
		dir_tab.push_back(row(100, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-128, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(127, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 1, 1, CMD_NONE_LIN, CMD_NONE_ANG, OUTCOME_NONE));
		run_table();
		drain();
		dir_tab.delete();

		// full region, extreme gains, width 0 and saturation
		set_region(0, -1024, 1023, -1024, 1023, 24'hFFFFFF, 24'h800000, 1);
		for (int i = 0; i < 6; i++) send_cell(100, i == 5);
		drain();
		set_region(2047, -1024, 1023, -1024, 1023, 24'h010000, 24'h7FFFFF, 1);
		for (int i = 0; i < 8; i++) send_cell(i[0] ? 8'sd100 : 8'sd0, i == 7);
		drain();
		// width change mid frame
		set_region(3, -1024, 1023, -1024, 1023, 24'h000100, 24'h010000, 1);
		for (int i = 0; i < 4; i++) send_cell(100, 0);
		in_valid <= 0; @(posedge clk);
		reg_write(REG_WIDTH, 1);
		for (int i = 0; i < 3; i++) send_cell(100, i == 2);
		drain();

		// random frames
		ncell = 0;
		while (ncell < 600) begin
			if ($urandom_range(0, 3) == 0)
				w = $urandom_range(1, 2047);
			else
				w = $urandom_range(1, 12);
			set_region(w, $urandom_range(0, 2047) - 1024 >>> ($urandom_range(0, 1) * 7),
				$urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024 >>> 7,
				$urandom_range(0, 2047) - 1024,
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536),
				$urandom, $urandom_range(0, 7) != 0);
			if ($urandom_range(0, 2) == 0) begin
				reg_write(REG_XLO, -20); reg_write(REG_XHI, 20);
				reg_write(REG_YLO, 0); reg_write(REG_YHI, 20);
			end
			repeat ($urandom_range(1, 60)) begin
				case ($urandom_range(0, 3))
					0: o = $urandom;
					1: o = -1;
					default: o = 100;
				endcase
				send_cell(o, 0);
				ncell++;
			end
			send_cell($urandom_range(0, 1) ? 8'sd100 : 8'sd0, 1);
			ncell++;
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/gca_pkg.sv
hw/rtl/gca_accum.sv
hw/rtl/gca_div.sv
hw/rtl/gca_cordic.sv
hw/rtl/grid_centroid_avoidance_cmd.sv
dv/grid_centroid_avoidance_cmd_tb.sv
